// ===== rtl/mrmc_pkg.sv =====
// Shared constants, codes and types of the masked region mean color block.
package mrmc_pkg;

   localparam int MAX_TILE_DIM = 64;

   // tile geometry widths follow the largest tile dimension
   localparam int DIM_W  = $clog2(MAX_TILE_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_TILE_DIM);
   localparam int AREA_W = 2 * DIM_W;

   // fixed field widths
   localparam int PIX_W      = 8;
   localparam int SUM_W      = 20;
   localparam int FRAC_W     = 8;
   localparam int MEAN_W     = 18;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

   // configuration port
   localparam int REG_W     = 7;
   localparam int SHAPE_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_TILE_ROWS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TILE_COLS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SHAPE_MODE = CSR_IDX_W'(2);

   localparam logic [REG_W-1:0]   TILE_ROWS_RESET  = REG_W'(8);
   localparam logic [REG_W-1:0]   TILE_COLS_RESET  = REG_W'(8);

   // shape codes
   localparam logic [SHAPE_W-1:0] SHAPE_RECT        = SHAPE_W'(0);
   localparam logic [SHAPE_W-1:0] SHAPE_UPPER_LEFT  = SHAPE_W'(1);
   localparam logic [SHAPE_W-1:0] SHAPE_LOWER_RIGHT = SHAPE_W'(2);
   localparam logic [SHAPE_W-1:0] SHAPE_UPPER_RIGHT = SHAPE_W'(3);
   localparam logic [SHAPE_W-1:0] SHAPE_LOWER_LEFT  = SHAPE_W'(4);

   localparam logic [SHAPE_W-1:0] SHAPE_MODE_RESET = SHAPE_RECT;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] idx;
      logic [REG_W-1:0]     data;
   } csr_write_type;

   typedef struct packed {
      logic              accept;
      logic              add;
      logic              load;
      logic              step;
      logic [AREA_W-1:0] divisor;
   } lane_ctl_type;

   typedef struct packed {
      logic xfer;
      logic fault;
   } ctl_status_type;

endpackage

// ===== rtl/mrmc_req_if.sv =====
// Pixel request channel of the masked region mean color block.
interface mrmc_req_if import mrmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pix_blue;
   logic [PIX_W-1:0] pix_green;
   logic [PIX_W-1:0] pix_red;

   modport source (output valid, output pix_blue, output pix_green, output pix_red,
                   input ready);
   modport sink   (input valid, input pix_blue, input pix_green, input pix_red,
                   output ready);
endinterface

// ===== rtl/mrmc_rsp_if.sv =====
// Mean result channel of the masked region mean color block.
interface mrmc_rsp_if import mrmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MEAN_W-1:0] mean_blue;
   logic [MEAN_W-1:0] mean_green;
   logic [MEAN_W-1:0] mean_red;
   logic              divide_fault;

   modport source (output valid, output mean_blue, output mean_green, output mean_red,
                   output divide_fault, input ready);
   modport sink   (input valid, input mean_blue, input mean_green, input mean_red,
                   input divide_fault, output ready);
endinterface

// ===== rtl/masked_region_mean_color.sv =====
// Top level: mean color of a masked tile region, three lanes merged into one result register.
//
//   channel   direction  handshake        payload
//   req_bus   in         valid / ready    pix_blue, pix_green, pix_red (8 bits each)
//   rsp_bus   out        valid / ready    mean_blue, mean_green, mean_red (18), divide_fault
//   csr_*     in         csr_we only      csr_index (2), csr_wdata (7)
//
// One pixel request is taken every cycle while a tile streams in.
// After the last pixel of a tile the request side stalls through the 28 steps of the bit-serial
// divider that each lane holds for itself, and until the means can move into the result
// register.
// The result register lets the next tile stream in while a result waits; if that tile ends
// before the result is taken, the divider holds its answer until the register frees up.
// Reset is synchronous: it clears sums, counters, the sequencer and the result valid, and
// loads the register defaults (8 x 8 tile, full rectangle).
module masked_region_mean_color import mrmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mrmc_req_if.sink             req_bus,
   mrmc_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   csr_write_type  csr;
   lane_ctl_type   lane_ctl;
   ctl_status_type status;
   logic           out_free;

   logic [MEAN_W-1:0] blue_lane, green_lane, red_lane;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0] blue_ff, blue_in;
   logic [MEAN_W-1:0] green_ff, green_in;
   logic [MEAN_W-1:0] red_ff, red_in;
   logic              fault_ff, fault_in;

   assign csr.we   = csr_we;
   assign csr.idx  = csr_index;
   assign csr.data = csr_wdata;

   // the result register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   mrmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .out_free  (out_free),
      .lane_ctl  (lane_ctl),
      .status    (status)
   );

   mrmc_lane u_lane_blue (
      .clock    (clock),
      .reset    (reset),
      .lane_ctl (lane_ctl),
      .pix      (req_bus.pix_blue),
      .mean     (blue_lane)
   );

   mrmc_lane u_lane_green (
      .clock    (clock),
      .reset    (reset),
      .lane_ctl (lane_ctl),
      .pix      (req_bus.pix_green),
      .mean     (green_lane)
   );

   mrmc_lane u_lane_red (
      .clock    (clock),
      .reset    (reset),
      .lane_ctl (lane_ctl),
      .pix      (req_bus.pix_red),
      .mean     (red_lane)
   );

   // merge stage: gather the lane means, force zeros on a zero divisor
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      red_in       = red_ff;
      fault_in     = fault_ff;
      if (status.xfer) begin
         rsp_valid_in = 1'b1;
         blue_in      = status.fault ? '0 : blue_lane;
         green_in     = status.fault ? '0 : green_lane;
         red_in       = status.fault ? '0 : red_lane;
         fault_in     = status.fault;
      end else if (rsp_bus.ready) begin
         // drop the result once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
      red_ff   <= red_in;
      fault_ff <= fault_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mean_blue    = blue_ff;
   assign rsp_bus.mean_green   = green_ff;
   assign rsp_bus.mean_red     = red_ff;
   assign rsp_bus.divide_fault = fault_ff;

endmodule

// ===== rtl/mrmc_ctrl.sv =====
// Tile controller: configuration registers, raster counters, shape mask, divide sequencing.
module mrmc_ctrl import mrmc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  csr_write_type  csr,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           out_free,
   output lane_ctl_type   lane_ctl,
   output ctl_status_type status
);

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] value);
      logic [DIM_W-1:0] dim;
      if (value == '0) begin
         dim = DIM_W'(1);
      end else if (int'(value) > MAX_TILE_DIM) begin
         dim = DIM_W'(MAX_TILE_DIM);
      end else begin
         dim = DIM_W'(value);
      end
      return dim;
   endfunction

   logic [1:0]         state_ff, state_in;
   logic [REG_W-1:0]   rows_ff, rows_in;
   logic [REG_W-1:0]   cols_ff, cols_in;
   logic [SHAPE_W-1:0] shape_ff, shape_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [AREA_W-1:0]  divisor_ff, divisor_in;
   logic               fault_ff, fault_in;

   logic [DIM_W-1:0]   h, w, c_ext, r_ext, c_next, r_next;
   logic [DIM_W:0]     diag;
   logic               row_end, tile_end, in_tile, hit, counts, accept;
   logic [AREA_W-1:0]  area, divisor_new;

   always_comb begin
      h       = eff_dim(rows_ff);
      w       = eff_dim(cols_ff);
      c_ext   = DIM_W'(col_ff);
      r_ext   = DIM_W'(row_ff);
      c_next  = c_ext + DIM_W'(1);
      r_next  = r_ext + DIM_W'(1);
      row_end = (c_next >= w);
      tile_end = row_end && (r_next >= h);
      diag    = {1'b0, c_ext} + {1'b0, r_ext};
      in_tile = (r_ext < h) && (c_ext < w);

      unique case (shape_ff)
         SHAPE_RECT:        hit = 1'b1;
         SHAPE_UPPER_LEFT:  hit = (diag < {1'b0, w});
         SHAPE_LOWER_RIGHT: hit = (diag >= {1'b0, w});
         SHAPE_UPPER_RIGHT: hit = (c_ext >= r_ext);
         SHAPE_LOWER_LEFT:  hit = (c_ext < r_ext);
         default:           hit = 1'b0;
      endcase
      counts = in_tile && hit;

      area        = AREA_W'(h) * AREA_W'(w);
      divisor_new = (shape_ff == SHAPE_RECT) ? area : (area >> 1);
   end

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;

   // configuration decode
   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      shape_in = shape_ff;
      if (csr.we) begin
         unique case (csr.idx)
            REG_TILE_ROWS:  rows_in  = csr.data;
            REG_TILE_COLS:  cols_in  = csr.data;
            REG_SHAPE_MODE: shape_in = csr.data[SHAPE_W-1:0];
            default:        ;
         endcase
      end
   end

   // raster counters and sequencer
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      fault_in   = fault_ff;

      if (accept) begin
         if (!row_end) begin
            col_in = CNT_W'(c_next);
         end else begin
            col_in = '0;
            row_in = (r_next < h) ? CNT_W'(r_next) : '0;
         end
      end

      unique case (state_ff)
         ST_RUN: begin
            if (accept && tile_end) begin
               state_in   = ST_DIV;
               step_in    = '0;
               divisor_in = divisor_new;
               fault_in   = (divisor_new == '0);
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         rows_ff  <= TILE_ROWS_RESET;
         cols_ff  <= TILE_COLS_RESET;
         shape_ff <= SHAPE_MODE_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         shape_ff <= shape_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      fault_ff   <= fault_in;
   end

   assign lane_ctl.accept  = accept;
   assign lane_ctl.add     = accept && counts;
   assign lane_ctl.load    = accept && tile_end;
   assign lane_ctl.step    = (state_ff == ST_DIV);
   assign lane_ctl.divisor = divisor_ff;

   assign status.xfer  = (state_ff == ST_HOLD) && out_free;
   assign status.fault = fault_ff;

endmodule

// ===== rtl/mrmc_lane.sv =====
// One color lane: masked channel sum and a bit-serial restoring divider.
module mrmc_lane import mrmc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lane_ctl_type      lane_ctl,
   input  logic [PIX_W-1:0]  pix,
   output logic [MEAN_W-1:0] mean
);

   logic [SUM_W-1:0]      sum_ff, sum_in, sum_upd;
   logic [AREA_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [AREA_W:0]       trial;

   always_comb begin
      sum_upd = lane_ctl.add ? (sum_ff + SUM_W'(pix)) : sum_ff;
      sum_in  = sum_ff;
      if (lane_ctl.accept) begin
         // clear on the last pixel of the tile
         sum_in = lane_ctl.load ? '0 : sum_upd;
      end

      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (lane_ctl.load) begin
         rem_in = '0;
         quo_in = {sum_upd, {FRAC_W{1'b0}}};
      end else if (lane_ctl.step) begin
         if (trial >= {1'b0, lane_ctl.divisor}) begin
            rem_in = AREA_W'(trial - {1'b0, lane_ctl.divisor});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[AREA_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // saturate the quotient to the 10.8 range
   assign mean = (quo_ff > DIVIDEND_W'(MEAN_MAX)) ? MEAN_MAX : quo_ff[MEAN_W-1:0];

endmodule

// ===== test/masked_region_mean_color_test.sv =====
// Self-checking bench for masked_region_mean_color: a directed table, then random tiles.
module masked_region_mean_color_test;
   import mrmc_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 12;
   // covers the 28 divide steps and the move into the result register, with margin on top
   localparam int DIVIDE_LATENCY = 40;
   localparam int RUN_LIMIT      = 20_000_000;
   localparam int RANDOM_PIXELS  = 1400;
   // keep random tiles small; one tall 64 x 8 tile is sent at the end
   localparam int AREA_CAP       = 512;
   localparam int TALL_COLS      = 8;
   localparam int REG_MAX        = 2**REG_W - 1;

   // shape codes the block does not define: no pixel counts, half-area divisor
   localparam logic [SHAPE_W-1:0] SHAPE_SPARE_LO = SHAPE_W'(5);
   localparam logic [SHAPE_W-1:0] SHAPE_SPARE_HI = SHAPE_W'(7);
   localparam logic [PIX_W-1:0]   PIX_FULL       = '1;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [MEAN_W-1:0] blue;
      logic [MEAN_W-1:0] green;
      logic [MEAN_W-1:0] red;
      logic              fault;
   } means_type;

   typedef enum logic {STEP_CSR, STEP_PIXEL} step_kind_type;

   // one row of the directed table: a register write, or a pixel sent reps times
   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [REG_W-1:0]     data;
      pixel_type            px;
      int                   reps;
      bit                   typed;
      means_type            means;
   } step_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   mrmc_req_if req_bus ();
   mrmc_rsp_if rsp_bus ();

   masked_region_mean_color dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the block's registers and tile state
   logic [REG_W-1:0]   rows_reg;
   logic [REG_W-1:0]   cols_reg;
   logic [SHAPE_W-1:0] shape_reg;
   logic [SUM_W-1:0]   sum_blue;
   logic [SUM_W-1:0]   sum_green;
   logic [SUM_W-1:0]   sum_red;
   logic [CNT_W-1:0]   row_at;
   logic [CNT_W-1:0]   col_at;

   means_type means_due[$];   // tile means still owed by the block, oldest first
   step_type  directed[$];
   int     errors = 0;
   int     random_pixels = 0;
   bit     req_gaps_on = 1'b1;
   bit     rsp_stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Guard against a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Register value to tile dimension: 0 acts as 1, anything above the maximum clamps.
   function automatic int unsigned clamp_dim(logic [REG_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_TILE_DIM) return MAX_TILE_DIM;
      return v;
   endfunction

   function automatic bit in_region(int unsigned r, int unsigned c, int unsigned h,
                                    int unsigned w);
      if (r >= h || c >= w) return 1'b0;
      case (shape_reg)
         SHAPE_RECT:        return 1'b1;
         SHAPE_UPPER_LEFT:  return c + r < w;
         SHAPE_LOWER_RIGHT: return c + r >= w;
         SHAPE_UPPER_RIGHT: return c >= r;
         SHAPE_LOWER_LEFT:  return c < r;
         default:           return 1'b0;
      endcase
   endfunction

   // (sum * 256) / divisor, truncated, saturated to the 10.8 range
   function automatic logic [MEAN_W-1:0] scaled_mean(logic [SUM_W-1:0] sum,
                                                    int unsigned divisor);
      longint unsigned q;
      q = sum;
      q = (q << FRAC_W) / divisor;
      if (q > MEAN_MAX) return MEAN_MAX;
      return q[MEAN_W-1:0];
   endfunction

   // Fold one pixel into the tile; return 1 and the means when it closes the tile.
   function automatic bit tile_means(input pixel_type px, output means_type m);
      int unsigned h;
      int unsigned w;
      int unsigned r;
      int unsigned c;
      int unsigned divisor;
      bit          done;
      h = clamp_dim(rows_reg);
      w = clamp_dim(cols_reg);
      r = row_at;
      c = col_at;
      done = 1'b0;
      m = '0;
      if (in_region(r, c, h, w)) begin
         sum_blue  = sum_blue + px.blue;
         sum_green = sum_green + px.green;
         sum_red   = sum_red + px.red;
      end
      // counters left past the edge by a register write still end the row or tile
      if (c + 1 < w) begin
         col_at = CNT_W'(c + 1);
      end else begin
         col_at = '0;
         if (r + 1 < h) begin
            row_at = CNT_W'(r + 1);
         end else begin
            done = 1'b1;
            divisor = (shape_reg == SHAPE_RECT) ? h * w : (h * w) >> 1;
            if (divisor == 0) begin
               m.fault = 1'b1;
            end else begin
               m.blue  = scaled_mean(sum_blue, divisor);
               m.green = scaled_mean(sum_green, divisor);
               m.red   = scaled_mean(sum_red, divisor);
            end
            sum_blue  = '0;
            sum_green = '0;
            sum_red   = '0;
            row_at    = '0;
         end
      end
      return done;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [REG_W-1:0] pick_dim();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return REG_W'($urandom_range(1, 8));
      if (pick < 85) return REG_W'($urandom_range(9, 24));
      if (pick < 92) return '0;
      return REG_W'($urandom_range(MAX_TILE_DIM, REG_MAX));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      case ($urandom_range(0, 7))
         0:       px = '{PIX_FULL, PIX_FULL, PIX_FULL};
         1:       px = '0;
         default: begin
            px.blue  = PIX_W'($urandom_range(0, 255));
            px.green = PIX_W'($urandom_range(0, 255));
            px.red   = PIX_W'($urandom_range(0, 255));
         end
      endcase
      return px;
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] index, logic [REG_W-1:0] data);
      step_type s;
      s.kind  = STEP_CSR;
      s.index = index;
      s.data  = data;
      s.px    = '0;
      s.reps  = 0;
      s.typed = 1'b0;
      s.means = '0;
      directed.push_back(s);
   endfunction

   // typed means, when given, apply to the last repetition only
   function automatic void add_pixels(pixel_type px, int reps, bit typed, means_type means);
      step_type s;
      s.kind  = STEP_PIXEL;
      s.index = '0;
      s.data  = '0;
      s.px    = px;
      s.reps  = reps;
      s.typed = typed;
      s.means = means;
      directed.push_back(s);
   endfunction

   // Drain the block, then write one register and mirror it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [REG_W-1:0] data);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (means_due.size() != 0) @(negedge clock);
      // a partial tile may still be in flight with nothing owed; let it settle
      repeat (DIVIDE_LATENCY) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_TILE_ROWS:  rows_reg = data;
         REG_TILE_COLS:  cols_reg = data;
         REG_SHAPE_MODE: shape_reg = data[SHAPE_W-1:0];
         default: ;
      endcase
   endtask

   // Send one pixel request, wait for its acceptance and book any result it closes.
   task automatic send_pixel(input pixel_type px, input bit typed,
                             input means_type typed_means);
      int        gap;
      means_type m;
      gap = req_gaps_on ? draw_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pix_blue  <= px.blue;
      req_bus.pix_green <= px.green;
      req_bus.pix_red   <= px.red;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (tile_means(px, m)) means_due.push_back(typed ? typed_means : m);
   endtask

   // Result side: stall in bursts of random length while stalls are on.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) hold = draw_gap();
         end
      end
   end

   // Check every accepted result against the oldest owed means.
   always @(posedge clock) begin
      means_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (means_due.size() == 0) begin
            errors++;
            $error("result with no tile pending: blue %0d green %0d red %0d fault %0d",
                   rsp_bus.mean_blue, rsp_bus.mean_green, rsp_bus.mean_red,
                   rsp_bus.divide_fault);
         end else begin
            want = means_due.pop_front();
            if (rsp_bus.mean_blue !== want.blue) begin
               errors++;
               $error("mean_blue: expected %0d, got %0d", want.blue, rsp_bus.mean_blue);
            end
            if (rsp_bus.mean_green !== want.green) begin
               errors++;
               $error("mean_green: expected %0d, got %0d", want.green, rsp_bus.mean_green);
            end
            if (rsp_bus.mean_red !== want.red) begin
               errors++;
               $error("mean_red: expected %0d, got %0d", want.red, rsp_bus.mean_red);
            end
            if (rsp_bus.divide_fault !== want.fault) begin
               errors++;
               $error("divide_fault: expected %0d, got %0d", want.fault,
                      rsp_bus.divide_fault);
            end
         end
      end
   end

   initial begin
      logic [SHAPE_W-1:0] triangles[4];
      logic [REG_W-1:0]   rows;
      logic [REG_W-1:0]   cols;
      logic [SHAPE_W-1:0] shape;
      int                 area;
      int                 extra;

      // hold every input at a known value from time zero
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.pix_blue  = '0;
      req_bus.pix_green = '0;
      req_bus.pix_red   = '0;

      rows_reg  = TILE_ROWS_RESET;
      cols_reg  = TILE_COLS_RESET;
      shape_reg = SHAPE_MODE_RESET;
      sum_blue  = '0;
      sum_green = '0;
      sum_red   = '0;
      row_at    = '0;
      col_at    = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed table ----
      // reset defaults: one full 8 x 8 rectangle of constant color
      add_pixels('{PIX_FULL, 8'd0, 8'd128}, 64, 1'b1,
                 '{18'h0FF00, 18'h00000, 18'h08000, 1'b0});
      // 1 x 1 rectangle: divisor 1, mean is the pixel itself shifted into 10.8
      add_csr(REG_TILE_ROWS, 7'd1);
      add_csr(REG_TILE_COLS, 7'd1);
      add_pixels('{8'd1, 8'd2, 8'd3}, 1, 1'b1, '{18'd256, 18'd512, 18'd768, 1'b0});
      // zero dimensions act as one
      add_csr(REG_TILE_ROWS, 7'd0);
      add_csr(REG_TILE_COLS, 7'd0);
      add_pixels('{PIX_FULL, 8'd0, 8'd1}, 1, 1'b1, '{18'h0FF00, 18'd0, 18'd256, 1'b0});
      // triangle on a 1 x 1 tile: zero divisor, fault and zero means
      add_csr(REG_SHAPE_MODE, REG_W'(SHAPE_UPPER_LEFT));
      add_pixels('{8'd9, 8'd9, 8'd9}, 1, 1'b1, '{18'd0, 18'd0, 18'd0, 1'b1});
      // undefined shape on a 1 x 1 tile: also a zero divisor
      add_csr(REG_SHAPE_MODE, REG_W'(SHAPE_SPARE_HI));
      add_pixels('{8'd200, 8'd100, 8'd50}, 1, 1'b1, '{18'd0, 18'd0, 18'd0, 1'b1});
      // every triangle on a 2 x 2 tile, each pixel tagged by its position
      add_csr(REG_TILE_ROWS, 7'd2);
      add_csr(REG_TILE_COLS, 7'd2);
      triangles = '{SHAPE_UPPER_LEFT, SHAPE_LOWER_RIGHT, SHAPE_UPPER_RIGHT, SHAPE_LOWER_LEFT};
      foreach (triangles[t]) begin
         add_csr(REG_SHAPE_MODE, REG_W'(triangles[t]));
         for (int k = 0; k < 4; k++)
            add_pixels('{PIX_W'(1 << k), PIX_W'(16 << k), PIX_W'(255 - k)}, 1, 1'b0, '0);
      end
      // undefined shape on 2 x 2: nothing counts, divisor 2, zero means without fault
      add_csr(REG_SHAPE_MODE, REG_W'(SHAPE_SPARE_LO));
      add_pixels('{PIX_FULL, PIX_FULL, PIX_FULL}, 4, 1'b1, '{18'd0, 18'd0, 18'd0, 1'b0});
      // width shrunk in mid-row: the column counter past the edge ends the row and tile
      add_csr(REG_SHAPE_MODE, REG_W'(SHAPE_RECT));
      add_csr(REG_TILE_ROWS, 7'd1);
      add_csr(REG_TILE_COLS, 7'd4);
      add_pixels('{8'd10, 8'd20, 8'd30}, 2, 1'b0, '0);
      add_csr(REG_TILE_COLS, 7'd2);
      add_pixels('{8'd40, 8'd50, 8'd60}, 1, 1'b0, '0);
      // height shrunk in mid-tile: the pixel on the row past the edge does not count
      add_csr(REG_TILE_ROWS, 7'd4);
      add_csr(REG_TILE_COLS, 7'd1);
      add_pixels('{8'd70, 8'd80, 8'd90}, 2, 1'b0, '0);
      add_csr(REG_TILE_ROWS, 7'd2);
      add_pixels('{PIX_FULL, PIX_FULL, PIX_FULL}, 1, 1'b0, '0);

      foreach (directed[i]) begin
         if (directed[i].kind == STEP_CSR) begin
            write_csr(directed[i].index, directed[i].data);
         end else begin
            for (int k = 0; k < directed[i].reps; k++)
               send_pixel(directed[i].px, directed[i].typed && k == directed[i].reps - 1,
                          directed[i].means);
         end
      end

      // ---- random phases: new setting, a few whole tiles, now and then a broken one ----
      while (random_pixels < RANDOM_PIXELS) begin
         rows = pick_dim();
         cols = pick_dim();
         while (clamp_dim(rows) * clamp_dim(cols) > AREA_CAP)
            cols = REG_W'($urandom_range(0, 8));
         if ($urandom_range(0, 99) < 85)
            shape = SHAPE_W'($urandom_range(SHAPE_RECT, SHAPE_LOWER_LEFT));
         else
            shape = SHAPE_W'($urandom_range(SHAPE_SPARE_LO, SHAPE_SPARE_HI));
         write_csr(REG_TILE_ROWS, rows);
         write_csr(REG_TILE_COLS, cols);
         write_csr(REG_SHAPE_MODE, REG_W'(shape));

         // leave some phases with no idling on either side
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;

         area  = clamp_dim(rows) * clamp_dim(cols);
         extra = 0;
         // drop the tail of the last tile so the next write lands in mid-tile
         if (area > 1 && $urandom_range(0, 4) == 0) extra = $urandom_range(1, area - 1);
         repeat ($urandom_range(1, 6) * area + extra) begin
            send_pixel(random_pixel(), 1'b0, '0);
            random_pixels++;
         end
      end

      // ---- one tall tile: an oversize row register clamps to 64, full divisor ----
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      write_csr(REG_TILE_ROWS, 7'd100);
      write_csr(REG_TILE_COLS, REG_W'(TALL_COLS));
      write_csr(REG_SHAPE_MODE, REG_W'(SHAPE_RECT));
      repeat (MAX_TILE_DIM * TALL_COLS) send_pixel(random_pixel(), 1'b0, '0);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (means_due.size() != 0) @(posedge clock);
      repeat (DIVIDE_LATENCY) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
